// ===== rtl/vnorm_pkg.sv =====
// Package for the 3D vector normalizer.
// Holds the fixed output field width and the default parameter values.
package vnorm_pkg;

   localparam int OUT_WIDTH          = 32;
   localparam int IN_WIDTH_DEFAULT   = 32;
   localparam int OUT_FRAC_DEFAULT   = 30;

endpackage

// ===== rtl/vnorm_if.sv =====
// Valid/ready channel interfaces for the 3D vector normalizer.
// Request carries the three signed components, response the unit vector.
interface vnorm_req_if #(parameter int IN_WIDTH = 32);
   logic                       valid;
   logic                       ready;
   logic signed [IN_WIDTH-1:0] x;
   logic signed [IN_WIDTH-1:0] y;
   logic signed [IN_WIDTH-1:0] z;

   modport source (output valid, x, y, z, input ready);
   modport sink   (input valid, x, y, z, output ready);
endinterface

interface vnorm_rsp_if #(parameter int OUT_WIDTH = 32);
   logic                        valid;
   logic                        ready;
   logic signed [OUT_WIDTH-1:0] unit_x;
   logic signed [OUT_WIDTH-1:0] unit_y;
   logic signed [OUT_WIDTH-1:0] unit_z;
   logic                        zero_length;

   modport source (output valid, unit_x, unit_y, unit_z, zero_length, input ready);
   modport sink   (input valid, unit_x, unit_y, unit_z, zero_length, output ready);
endinterface

// ===== rtl/vnorm_square.sv =====
// Front end of the normalizer: magnitudes, split squares, sum of squares.
// Four register stages; depends on vnorm_pkg.
module vnorm_square #(
   parameter int IN_WIDTH      = 32,
   parameter int OUT_FRAC_BITS = 30
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   enable,
   input  logic                                   in_valid,
   input  logic [2:0][IN_WIDTH-1:0]               in_comp,
   output logic                                   out_valid,
   output logic [2*IN_WIDTH-1:0]                  out_sum,
   output logic [2:0][2*IN_WIDTH+2*OUT_FRAC_BITS-1:0] out_rem,
   output logic [2:0]                             out_neg,
   output logic                                   out_zero
);
   import vnorm_pkg::*;

   localparam int W  = IN_WIDTH;
   localparam int H  = (W + 1) / 2;
   localparam int L  = W - H;
   localparam int SW = 2 * W;
   localparam int RW = 2 * W + 2 * OUT_FRAC_BITS;

   logic [2:0]             a_valid_ff, a_valid_in;
   logic [2:0][W-1:0]      a_mag_ff, a_mag_in;
   logic [2:0]             a_neg_ff, a_neg_in;

   logic [2:0][2*L-1:0]    b_hh_ff, b_hh_in;
   logic [2:0][W-1:0]      b_hl_ff, b_hl_in;
   logic [2:0][2*H-1:0]    b_ll_ff, b_ll_in;
   logic [2:0]             b_neg_ff;
   logic                   b_zero_ff, b_zero_in;

   logic [2:0][SW-1:0]     c_sq_ff, c_sq_in;
   logic [2:0]             c_neg_ff;
   logic                   c_zero_ff;

   logic                   d_valid_ff;
   logic [SW-1:0]          d_sum_ff, d_sum_in;
   logic [2:0][RW-1:0]     d_rem_ff, d_rem_in;
   logic [2:0]             d_neg_ff;
   logic                   d_zero_ff;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         a_neg_in[i] = in_comp[i][W-1];
         a_mag_in[i] = a_neg_in[i] ? (~in_comp[i] + W'(1)) : in_comp[i];
         b_hh_in[i]  = (2*L)'(a_mag_ff[i][W-1:H]) * (2*L)'(a_mag_ff[i][W-1:H]);
         b_hl_in[i]  = W'(a_mag_ff[i][W-1:H]) * W'(a_mag_ff[i][H-1:0]);
         b_ll_in[i]  = (2*H)'(a_mag_ff[i][H-1:0]) * (2*H)'(a_mag_ff[i][H-1:0]);
         c_sq_in[i]  = (SW'(b_hh_ff[i]) << (2*H)) + (SW'(b_hl_ff[i]) << (H+1))
                       + SW'(b_ll_ff[i]);
         d_rem_in[i] = RW'(c_sq_ff[i]) << (2*OUT_FRAC_BITS);
      end
      a_valid_in = {a_valid_ff[1:0], in_valid};
      b_zero_in  = (a_mag_ff[0] == '0) && (a_mag_ff[1] == '0) && (a_mag_ff[2] == '0);
      d_sum_in   = c_sq_ff[0] + c_sq_ff[1] + c_sq_ff[2];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= '0;
         d_valid_ff <= 1'b0;
      end else if (enable) begin
         a_valid_ff <= a_valid_in;
         d_valid_ff <= a_valid_ff[2];
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         a_mag_ff  <= a_mag_in;
         a_neg_ff  <= a_neg_in;
         b_hh_ff   <= b_hh_in;
         b_hl_ff   <= b_hl_in;
         b_ll_ff   <= b_ll_in;
         b_neg_ff  <= a_neg_ff;
         b_zero_ff <= b_zero_in;
         c_sq_ff   <= c_sq_in;
         c_neg_ff  <= b_neg_ff;
         c_zero_ff <= b_zero_ff;
         d_sum_ff  <= d_sum_in;
         d_rem_ff  <= d_rem_in;
         d_neg_ff  <= c_neg_ff;
         d_zero_ff <= c_zero_ff;
      end
   end

   assign out_valid = d_valid_ff;
   assign out_sum   = d_sum_ff;
   assign out_rem   = d_rem_ff;
   assign out_neg   = d_neg_ff;
   assign out_zero  = d_zero_ff;

endmodule

// ===== rtl/vnorm_step.sv =====
// One quotient bit of the normalizer: trial subtract of the scaled sum.
// Keeps remainder m^2*2^2F - q^2*S and running product q*S; uses vnorm_pkg.
module vnorm_step #(
   parameter int IN_WIDTH      = 32,
   parameter int OUT_FRAC_BITS = 30,
   parameter int BIT_POS       = 0
) (
   input  logic                                       clock,
   input  logic                                       reset,
   input  logic                                       enable,
   input  logic                                       in_valid,
   input  logic [2*IN_WIDTH-1:0]                      in_sum,
   input  logic [2:0][2*IN_WIDTH+2*OUT_FRAC_BITS-1:0] in_rem,
   input  logic [2:0][2*IN_WIDTH+OUT_FRAC_BITS:0]     in_prod,
   input  logic [2:0][OUT_FRAC_BITS:0]                in_quo,
   input  logic [2:0]                                 in_neg,
   input  logic                                       in_zero,
   output logic                                       out_valid,
   output logic [2*IN_WIDTH-1:0]                      out_sum,
   output logic [2:0][2*IN_WIDTH+2*OUT_FRAC_BITS-1:0] out_rem,
   output logic [2:0][2*IN_WIDTH+OUT_FRAC_BITS:0]     out_prod,
   output logic [2:0][OUT_FRAC_BITS:0]                out_quo,
   output logic [2:0]                                 out_neg,
   output logic                                       out_zero
);
   import vnorm_pkg::*;

   localparam int SW = 2 * IN_WIDTH;
   localparam int RW = 2 * IN_WIDTH + 2 * OUT_FRAC_BITS;
   localparam int TW = 2 * IN_WIDTH + OUT_FRAC_BITS + 1;
   localparam int DW = 2 * IN_WIDTH + 2 * OUT_FRAC_BITS + 3;
   localparam int QW = OUT_FRAC_BITS + 1;

   logic                valid_ff;
   logic [SW-1:0]       sum_ff;
   logic [2:0][RW-1:0]  rem_ff, rem_in;
   logic [2:0][TW-1:0]  prod_ff, prod_in;
   logic [2:0][QW-1:0]  quo_ff, quo_in;
   logic [2:0]          neg_ff;
   logic                zero_ff;
   logic [2:0][DW-1:0]  trial;
   logic [2:0]          take;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         trial[i]   = (DW'(in_prod[i]) << (BIT_POS + 1)) + (DW'(in_sum) << (2 * BIT_POS));
         take[i]    = trial[i] <= DW'(in_rem[i]);
         rem_in[i]  = take[i] ? (in_rem[i] - trial[i][RW-1:0]) : in_rem[i];
         prod_in[i] = take[i] ? (in_prod[i] + (TW'(in_sum) << BIT_POS)) : in_prod[i];
         quo_in[i]  = in_quo[i] | (QW'(take[i]) << BIT_POS);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (enable) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         sum_ff  <= in_sum;
         rem_ff  <= rem_in;
         prod_ff <= prod_in;
         quo_ff  <= quo_in;
         neg_ff  <= in_neg;
         zero_ff <= in_zero;
      end
   end

   assign out_valid = valid_ff;
   assign out_sum   = sum_ff;
   assign out_rem   = rem_ff;
   assign out_prod  = prod_ff;
   assign out_quo   = quo_ff;
   assign out_neg   = neg_ff;
   assign out_zero  = zero_ff;

endmodule

// ===== rtl/vector3_normalize_core.sv =====
// Top level of the 3D vector normalizer: front end, bit chain, output stage.
// Depends on vnorm_pkg, vnorm_if, vnorm_square and vnorm_step.
//
// Accepts one Q16.16 vector per cycle and returns c * 2^OUT_FRAC_BITS / |v| for
// each component, truncated toward zero, with zero_length set and zero
// components for a null vector. The pipeline has four front stages for
// magnitude, split squares and sum, one stage per quotient bit of the
// shift-and-subtract root division chain, and one output stage. Throughput
// is one vector per cycle; a stalled response freezes the whole pipeline.
module vector3_normalize_core #(
   parameter int IN_WIDTH      = vnorm_pkg::IN_WIDTH_DEFAULT,
   parameter int OUT_FRAC_BITS = vnorm_pkg::OUT_FRAC_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   vnorm_req_if.sink   req_chan,
   vnorm_rsp_if.source rsp_chan
);
   import vnorm_pkg::*;

   localparam int SW    = 2 * IN_WIDTH;
   localparam int RW    = 2 * IN_WIDTH + 2 * OUT_FRAC_BITS;
   localparam int TW    = 2 * IN_WIDTH + OUT_FRAC_BITS + 1;
   localparam int QW    = OUT_FRAC_BITS + 1;
   localparam int NSTEP = OUT_FRAC_BITS + 1;
   localparam int XW    = 64;

   logic                          enable;
   logic [NSTEP:0]                chain_valid;
   logic [NSTEP:0][SW-1:0]        chain_sum;
   logic [NSTEP:0][2:0][RW-1:0]   chain_rem;
   logic [NSTEP:0][2:0][TW-1:0]   chain_prod;
   logic [NSTEP:0][2:0][QW-1:0]   chain_quo;
   logic [NSTEP:0][2:0]           chain_neg;
   logic [NSTEP:0]                chain_zero;

   logic                          out_valid_ff;
   logic [2:0][OUT_WIDTH-1:0]     unit_ff, unit_in;
   logic                          zero_ff;
   logic [2:0][XW-1:0]            quo_ext;

   assign enable         = !out_valid_ff || rsp_chan.ready;
   assign req_chan.ready = enable;

   vnorm_square #(
      .IN_WIDTH      (IN_WIDTH),
      .OUT_FRAC_BITS (OUT_FRAC_BITS)
   ) u_square (
      .clock     (clock),
      .reset     (reset),
      .enable    (enable),
      .in_valid  (req_chan.valid),
      .in_comp   ({req_chan.z, req_chan.y, req_chan.x}),
      .out_valid (chain_valid[0]),
      .out_sum   (chain_sum[0]),
      .out_rem   (chain_rem[0]),
      .out_neg   (chain_neg[0]),
      .out_zero  (chain_zero[0])
   );

   assign chain_prod[0] = '0;
   assign chain_quo[0]  = '0;

   for (genvar k = 0; k < NSTEP; k++) begin : g_step
      vnorm_step #(
         .IN_WIDTH      (IN_WIDTH),
         .OUT_FRAC_BITS (OUT_FRAC_BITS),
         .BIT_POS       (OUT_FRAC_BITS - k)
      ) u_step (
         .clock     (clock),
         .reset     (reset),
         .enable    (enable),
         .in_valid  (chain_valid[k]),
         .in_sum    (chain_sum[k]),
         .in_rem    (chain_rem[k]),
         .in_prod   (chain_prod[k]),
         .in_quo    (chain_quo[k]),
         .in_neg    (chain_neg[k]),
         .in_zero   (chain_zero[k]),
         .out_valid (chain_valid[k+1]),
         .out_sum   (chain_sum[k+1]),
         .out_rem   (chain_rem[k+1]),
         .out_prod  (chain_prod[k+1]),
         .out_quo   (chain_quo[k+1]),
         .out_neg   (chain_neg[k+1]),
         .out_zero  (chain_zero[k+1])
      );
   end

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         quo_ext[i] = XW'(chain_quo[NSTEP][i]);
         if (chain_zero[NSTEP]) begin
            unit_in[i] = '0;
         end else if (chain_neg[NSTEP][i]) begin
            unit_in[i] = OUT_WIDTH'(~quo_ext[i] + XW'(1));
         end else begin
            unit_in[i] = OUT_WIDTH'(quo_ext[i]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (enable) begin
         out_valid_ff <= chain_valid[NSTEP];
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         unit_ff <= unit_in;
         zero_ff <= chain_zero[NSTEP];
      end
   end

   assign rsp_chan.valid       = out_valid_ff;
   assign rsp_chan.unit_x      = unit_ff[0];
   assign rsp_chan.unit_y      = unit_ff[1];
   assign rsp_chan.unit_z      = unit_ff[2];
   assign rsp_chan.zero_length = zero_ff;

   a_zero_units: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && rsp_chan.zero_length |->
         rsp_chan.unit_x == '0 && rsp_chan.unit_y == '0 && rsp_chan.unit_z == '0)
      else $error("zero-length response with nonzero components");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_chan.valid)
      else $error("response valid right after reset");

   a_stall_freeze: assert property (@(posedge clock) disable iff (reset)
      !enable |=> $stable(chain_valid) && $stable(chain_quo[NSTEP]))
      else $error("pipeline advanced during stall");

endmodule
